>>> rtl/knnsl_pkg.sv
package knnsl_pkg;

  localparam int OP_W   = 2;
  localparam int NODE_W = 10;
  localparam int SLOT_W = 4;
  localparam int ID_W   = 10;
  localparam int DIST_W = 32;

  typedef enum logic [OP_W-1:0] {
    OP_OFFER = 2'd0,
    OP_LOAD  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  // One stored neighbor entry.
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [DIST_W-1:0] dist_key;
    logic              fresh;
  } entry_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;  // latch the item and start the row read
    logic execute;  // update the row, write it back and load the result
  } ctrl_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_stall;  // result register full and not being taken
  } ctrl_stat_t;

endpackage

>>> rtl/knnsl_if.sv
interface knnsl_item_if;
  import knnsl_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [NODE_W-1:0] node;
  logic [SLOT_W-1:0] slot;
  logic [ID_W-1:0]   neighbor_id;
  logic [DIST_W-1:0] neighbor_dist;
  logic              neighbor_new;

  modport source(output valid, op, node, slot, neighbor_id, neighbor_dist, neighbor_new,
                 input ready);
  modport sink(input valid, op, node, slot, neighbor_id, neighbor_dist, neighbor_new,
               output ready);
endinterface

interface knnsl_result_if;
  import knnsl_pkg::*;

  logic              valid;
  logic              ready;
  logic              accepted;
  logic [ID_W-1:0]   read_id;
  logic [DIST_W-1:0] read_dist;
  logic              read_new;

  modport source(output valid, accepted, read_id, read_dist, read_new, input ready);
  modport sink(input valid, accepted, read_id, read_dist, read_new, output ready);
endinterface

>>> rtl/knnsl_ctrl.sv
module knnsl_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output knnsl_pkg::ctrl_cmd_t  cmd,
  input  knnsl_pkg::ctrl_stat_t stat
);
  import knnsl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  assign item_ready  = (state == S_IDLE);
  assign cmd.capture = (state == S_IDLE) && item_valid;
  // The update waits while the previous result is still held downstream.
  assign cmd.execute = (state == S_EXEC) && !stat.out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.capture) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.execute) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == S_EXEC) && !item_ready)
    else $error("transaction taken but controller not busy");
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && stat.out_stall |=> (state == S_EXEC))
    else $error("update left while result register stalled");
  a_state_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot(state))
    else $error("controller state is not one-hot");
`endif

endmodule

>>> rtl/knnsl_dp.sv
module knnsl_dp #(
  parameter int NODES = 1024,
  parameter int K     = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  knnsl_pkg::ctrl_cmd_t             cmd,
  output knnsl_pkg::ctrl_stat_t            stat,
  input  logic [knnsl_pkg::OP_W-1:0]       op,
  input  logic [knnsl_pkg::NODE_W-1:0]     node,
  input  logic [knnsl_pkg::SLOT_W-1:0]     slot,
  input  logic [knnsl_pkg::ID_W-1:0]       neighbor_id,
  input  logic [knnsl_pkg::DIST_W-1:0]     neighbor_dist,
  input  logic                             neighbor_new,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic                             accepted,
  output logic [knnsl_pkg::ID_W-1:0]       read_id,
  output logic [knnsl_pkg::DIST_W-1:0]     read_dist,
  output logic                             read_new
);
  import knnsl_pkg::*;

  // Only nodes reachable through the node field get a row.
  localparam int ROWS = (NODES < (1 << NODE_W)) ? NODES : (1 << NODE_W);
  localparam int AW   = $clog2(ROWS);

  entry_t [K-1:0] mem [ROWS];
  entry_t [K-1:0] rd_row;
  entry_t [K-1:0] row_next;

  logic [OP_W-1:0]   op_q;
  logic [NODE_W-1:0] node_q;
  logic [SLOT_W-1:0] slot_q;
  entry_t            cand;

  logic [K-1:0] hit;
  logic [K-1:0] gt;
  logic [K-1:0] suf;
  logic         offer_ok;
  logic         node_ok;
  logic         slot_ok;
  entry_t       sel;
  logic         acc;
  logic         wr_en;
  int           p;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op;
      node_q <= node;
      slot_q <= slot;
      cand   <= '{id: neighbor_id, dist_key: neighbor_dist, fresh: neighbor_new};
      rd_row <= mem[node[AW-1:0]];
    end
    if (wr_en) begin
      mem[node_q[AW-1:0]] <= row_next;
    end
  end

  assign node_ok = int'(node_q) < NODES;
  assign slot_ok = int'(slot_q) < K;

  always_comb begin
    p = 0;
    for (int i = 0; i < K; i++) begin
      hit[i] = (rd_row[i].id == cand.id);
      gt[i]  = (rd_row[i].dist_key > cand.dist_key);
    end
    // suf[i]: every entry from i down to the second to last lies above the
    // candidate, so slot i is inside the region that shifts.
    suf[K-1] = 1'b1;
    for (int i = K - 2; i >= 0; i--) begin
      suf[i] = suf[i+1] & gt[i];
    end
    offer_ok = !(|hit) && gt[K-1];

    row_next = rd_row;
    sel      = '0;
    for (int i = 0; i < K; i++) begin
      p = (i > 0) ? i - 1 : 0;
      if (op_q == OP_OFFER && suf[i]) begin
        row_next[i] = (i > 0 && suf[p]) ? rd_row[p] : cand;
      end
      if (int'(slot_q) == i) begin
        sel = rd_row[i];
        if (op_q == OP_LOAD) row_next[i] = cand;
      end
    end
  end

  assign acc   = (op_q == OP_OFFER) && node_ok && offer_ok;
  assign wr_en = cmd.execute && node_ok && (acc || ((op_q == OP_LOAD) && slot_ok));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.execute) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      accepted <= acc;
      if ((op_q == OP_READ) && node_ok && slot_ok) begin
        read_id   <= sel.id;
        read_dist <= sel.dist_key;
        read_new  <= sel.fresh;
      end else begin
        read_id   <= '0;
        read_dist <= '0;
        read_new  <= 1'b0;
      end
    end
  end

  assign stat.out_stall = out_valid && !out_ready;

`ifndef NO_ASSERTIONS
  a_exec_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |=> out_valid)
    else $error("update finished without a result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.execute |-> !stat.out_stall)
    else $error("result register overwritten while stalled");
  a_acc_offer: assert property (@(posedge clk) disable iff (rst)
    cmd.execute && acc |-> (op_q == OP_OFFER) && wr_en)
    else $error("acceptance without a list write");
`endif

endmodule

>>> rtl/knn_sorted_list_insert_core.sv
// Sorted top-K neighbor list store.
// Each node owns a list of K entries (id, distance key, new flag) kept in
// ascending distance order, one list per memory row. The item channel takes
// three kinds of transaction: an offer inserts a candidate unless its id is
// already listed or its distance is not strictly below the last entry; a
// load writes one entry at a slot; a read returns one entry. Every item
// produces exactly one transaction on the result channel, in order.
// Timing: an item is accepted when the block is idle; the node's whole row
// is read into a register at that edge. In the update state the row is
// updated, written back and registered into the result, and the result
// valid is set. No new item is taken until the update is done, as the row
// read is followed by the row write-back, so items never overlap.
// If the result register is still held because the receiver stalls, the
// pending update waits and no further item is accepted until it is drained.
// Reset clears the controller and the result valid; list contents are
// undefined until loaded, and nodes must be loaded before they are offered
// to or read.
module knn_sorted_list_insert_core #(
  parameter int NODES = 1024,
  parameter int K     = 16
) (
  input logic            clk,
  input logic            rst,
  knnsl_item_if.sink     item,
  knnsl_result_if.source result
);
  import knnsl_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  // Controller: sequences capture and update and owns the input ready.
  knnsl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  // Datapath: row memory, compare-and-shift insertion and result register.
  knnsl_dp #(
    .NODES (NODES),
    .K     (K)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .op            (item.op),
    .node          (item.node),
    .slot          (item.slot),
    .neighbor_id   (item.neighbor_id),
    .neighbor_dist (item.neighbor_dist),
    .neighbor_new  (item.neighbor_new),
    .out_ready     (result.ready),
    .out_valid     (result.valid),
    .accepted      (result.accepted),
    .read_id       (result.read_id),
    .read_dist     (result.read_dist),
    .read_new      (result.read_new)
  );

endmodule

>>> dv/knnsl_list_monitor.sv
module knnsl_list_monitor #(
  parameter int NODES = 1024,
  parameter int K     = 16
) (
  input  logic    clk,
  input  logic    rst,
  knnsl_item_if   item,
  knnsl_result_if result,
  output int      fail_count,
  output int      pending
);
  import knnsl_pkg::*;

  typedef struct packed {
    logic              accepted;
    logic [ID_W-1:0]   read_id;
    logic [DIST_W-1:0] read_dist;
    logic              read_new;
  } list_result_t;

  // Mirror of every node's neighbor list, indexed node*K+slot.
  entry_t       lists [NODES*K];
  list_result_t results_due [$];
  int           mismatches = 0;
  int           waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  initial begin
    foreach (lists[i]) lists[i] = '0;
  end

  // Inserts a candidate into the list at base, keeping ascending distance order.
  function automatic logic insert_candidate(int base, logic [ID_W-1:0] cid,
                                            logic [DIST_W-1:0] cdist, logic cfresh);
    int pos;
    for (int i = 0; i < K; i++) begin
      if (lists[base+i].id == cid) return 1'b0;
    end
    if (lists[base+K-1].dist_key <= cdist) return 1'b0;
    pos = K - 1;
    while (pos > 0 && lists[base+pos-1].dist_key > cdist) begin
      lists[base+pos] = lists[base+pos-1];
      pos--;
    end
    lists[base+pos] = '{id: cid, dist_key: cdist, fresh: cfresh};
    return 1'b1;
  endfunction

  function automatic list_result_t predict_list_op(logic [OP_W-1:0] op,
                                                   logic [NODE_W-1:0] node,
                                                   logic [SLOT_W-1:0] slot,
                                                   logic [ID_W-1:0] nid,
                                                   logic [DIST_W-1:0] ndist,
                                                   logic nnew);
    list_result_t res;
    int base;
    res  = '0;
    base = int'(node) * K;
    if (int'(node) < NODES) begin
      case (op)
        OP_OFFER: res.accepted = insert_candidate(base, nid, ndist, nnew);
        OP_LOAD: begin
          if (int'(slot) < K) lists[base+slot] = '{id: nid, dist_key: ndist, fresh: nnew};
        end
        OP_READ: begin
          if (int'(slot) < K) begin
            res.read_id   = lists[base+slot].id;
            res.read_dist = lists[base+slot].dist_key;
            res.read_new  = lists[base+slot].fresh;
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  function automatic void check_field(string field, logic [DIST_W-1:0] want,
                                      logic [DIST_W-1:0] got);
    if (got !== want) begin
      $display("%0t knnsl_list_monitor: %s mismatch, expected %0h, actual %0h",
               $time, field, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    list_result_t want;
    if (!rst) begin
      if (result.valid && result.ready) begin
        if (results_due.size() == 0) begin
          $display("%0t knnsl_list_monitor: unexpected result transaction, accepted %0h id %0h",
                   $time, result.accepted, result.read_id);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("accepted", DIST_W'(want.accepted), DIST_W'(result.accepted));
          check_field("read_id", DIST_W'(want.read_id), DIST_W'(result.read_id));
          check_field("read_dist", want.read_dist, result.read_dist);
          check_field("read_new", DIST_W'(want.read_new), DIST_W'(result.read_new));
        end
      end
      if (item.valid && item.ready) begin
        results_due.insert(results_due.size(),
                           predict_list_op(item.op, item.node, item.slot,
                                           item.neighbor_id, item.neighbor_dist,
                                           item.neighbor_new));
      end
      waiting = results_due.size();
    end
  end

endmodule

>>> dv/knn_sorted_list_insert_core_tb.sv
// Testbench top for the sorted top-K neighbor list store.
// This module only makes stimulus and gives the verdict. The list monitor
// beside the block watches both channels, predicts every result from its own
// copy of the lists and counts mismatches.
module knn_sorted_list_insert_core_tb;
  import knnsl_pkg::*;

  localparam int NODE_COUNT   = 1024;
  localparam int LIST_LEN     = 16;
  localparam int POOL_SIZE    = 12;
  localparam int RANDOM_ITEMS = 1700;
  localparam int LONG_HOLD    = 400;
  // The op code that the package leaves without a name; the block must ignore it.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk;
  logic rst;

  knnsl_item_if   item_ch();
  knnsl_result_if result_ch();

  int fail_count;
  int outstanding;
  bit random_phase = 1'b0;
  int burst_left = 0;
  int items_sent = 0;

  // Which slots of each node have been written. Offers touch the whole list,
  // so they only go to nodes whose every slot is written; reads only to
  // written slots.
  logic [LIST_LEN-1:0] slot_written [NODE_COUNT];

  // A small pool of nodes carries most of the traffic, so lists evolve over
  // many offers. Each node has its own id and distance spans: narrow spans
  // give duplicate ids and equal distances, wide spans reach every bit.
  logic [NODE_W-1:0] pool_node [POOL_SIZE];
  int unsigned       pool_id_span [POOL_SIZE];
  int unsigned       pool_dist_span [POOL_SIZE];

  knn_sorted_list_insert_core #(
    .NODES(NODE_COUNT),
    .K    (LIST_LEN)
  ) DUT (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch)
  );

  knnsl_list_monitor #(
    .NODES(NODE_COUNT),
    .K    (LIST_LEN)
  ) list_monitor (
    .clk       (clk),
    .rst       (rst),
    .item      (item_ch),
    .result    (result_ch),
    .fail_count(fail_count),
    .pending   (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drives one item starting at a falling edge and returns at the falling
  // edge after its transaction. The sender works in bursts; between bursts it
  // usually drops valid for a few cycles. Valid stays high across items in a
  // burst, so it is never lowered and raised in the same step.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [NODE_W-1:0] node,
                           input logic [SLOT_W-1:0] slot, input logic [ID_W-1:0] nid,
                           input logic [DIST_W-1:0] ndist, input logic nnew);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        item_ch.valid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      // An occasional long burst gives stretches with no sender gaps at all.
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                               : $urandom_range(1, 20);
    end
    item_ch.valid         = 1'b1;
    item_ch.op            = op;
    item_ch.node          = node;
    item_ch.slot          = slot;
    item_ch.neighbor_id   = nid;
    item_ch.neighbor_dist = ndist;
    item_ch.neighbor_new  = nnew;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
    if (op == OP_LOAD) slot_written[node][slot] = 1'b1;
  endtask

  // Writes all K entries of a pool node. A sorted fill builds distances by
  // random steps, where a zero step makes a tie; an unsorted fill writes
  // random distances in any order, which the block must still handle.
  task automatic fill_list(input int p, input bit sorted);
    longint unsigned acc;
    int unsigned     step_max;
    logic [DIST_W-1:0] d;
    acc      = 0;
    step_max = pool_dist_span[p] / LIST_LEN;
    for (int s = 0; s < LIST_LEN; s++) begin
      if (sorted) begin
        acc += $urandom_range(0, step_max);
        if (acc > pool_dist_span[p]) acc = pool_dist_span[p];
        d = DIST_W'(acc);
      end else begin
        d = $urandom_range(0, pool_dist_span[p]);
      end
      send_item(OP_LOAD, pool_node[p], SLOT_W'(s),
                ID_W'($urandom_range(0, pool_id_span[p])), d, 1'($urandom_range(0, 1)));
    end
  endtask

  // Stimulus: reset, a directed list on the top node, then random traffic.
  initial begin
    int                p;
    int                pick;
    int                target;
    logic [NODE_W-1:0] n;
    int unsigned       span;
    logic [DIST_W-1:0] cand_dist;

    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.op            = OP_OFFER;
    item_ch.node          = '0;
    item_ch.slot          = '0;
    item_ch.neighbor_id   = '0;
    item_ch.neighbor_dist = '0;
    item_ch.neighbor_new  = 1'b0;
    foreach (slot_written[i]) slot_written[i] = '0;

    pool_node[0] = '0;
    pool_node[1] = '1;
    for (int i = 0; i < POOL_SIZE; i++) begin
      if (i > 1) pool_node[i] = NODE_W'($urandom_range(1, NODE_COUNT - 2));
      pool_id_span[i] = ($urandom_range(0, 1) == 0) ? 31 : NODE_COUNT - 1;
      case ($urandom_range(0, 2))
        0:       pool_dist_span[i] = 63;
        1:       pool_dist_span[i] = 65535;
        default: pool_dist_span[i] = 32'hFFFF_FFFF;
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed list on the highest node: ids at the top of the range, the
    // first slot at distance zero, a tie between slots 3 and 4 and the last
    // slot at the largest distance.
    for (int s = 0; s < LIST_LEN; s++) begin
      send_item(OP_LOAD, '1, SLOT_W'(s), ID_W'(1008 + s),
                (s == 0) ? DIST_W'(0) :
                (s == 4) ? DIST_W'(3000) :
                (s == LIST_LEN - 1) ? '1 : DIST_W'(s * 1000),
                s[0]);
    end
    send_item(OP_READ, '1, SLOT_W'(LIST_LEN - 1), '0, '0, 1'b0);
    // A distance equal to the last entry is not strictly below it.
    send_item(OP_OFFER, '1, '0, '0, '1, 1'b1);
    // An id that is already listed is rejected whatever its distance.
    send_item(OP_OFFER, '1, '0, ID_W'(1010), DIST_W'(5), 1'b0);
    // Just below the last entry: replaces it.
    send_item(OP_OFFER, '1, '0, '0, 32'hFFFF_FFFE, 1'b1);
    // Equal to the first entry's distance: lands right after it.
    send_item(OP_OFFER, '1, '0, ID_W'(1), '0, 1'b1);
    // Equal to the tied pair: lands after both.
    send_item(OP_OFFER, '1, '0, ID_W'(2), DIST_W'(3000), 1'b0);
    send_item(OP_READ, '1, '0, '0, '0, 1'b0);
    send_item(OP_READ, '1, SLOT_W'(1), '0, '0, 1'b0);
    send_item(OP_READ, '1, SLOT_W'(LIST_LEN - 1), '0, '0, 1'b0);
    send_item(OP_UNUSED, '1, '1, '1, '1, 1'b1);

    // Random traffic. Mostly offers and reads on filled lists, with some
    // single-slot overwrites, refills and unused op codes as noise.
    random_phase = 1'b1;
    target       = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      p    = $urandom_range(0, POOL_SIZE - 1);
      n    = pool_node[p];
      span = pool_dist_span[p];
      pick = $urandom_range(0, 99);
      if (slot_written[n] != '1) begin
        fill_list(p, $urandom_range(0, 9) != 0);
      end else if (pick < 60) begin
        if ($urandom_range(0, 15) == 0) cand_dist = pick[0] ? DIST_W'(span) : '0;
        else cand_dist = $urandom_range(0, span);
        send_item(OP_OFFER, n, SLOT_W'($urandom_range(0, LIST_LEN - 1)),
                  ID_W'($urandom_range(0, pool_id_span[p])), cand_dist,
                  1'($urandom_range(0, 1)));
      end else if (pick < 84) begin
        send_item(OP_READ, n, SLOT_W'($urandom_range(0, LIST_LEN - 1)),
                  ID_W'($urandom_range(0, 1023)), $urandom(), 1'($urandom_range(0, 1)));
      end else if (pick < 92) begin
        send_item(OP_LOAD, n, SLOT_W'($urandom_range(0, LIST_LEN - 1)),
                  ID_W'($urandom_range(0, pool_id_span[p])), $urandom_range(0, span),
                  1'($urandom_range(0, 1)));
      end else if (pick < 96) begin
        send_item(OP_UNUSED, NODE_W'($urandom_range(0, NODE_COUNT - 1)),
                  SLOT_W'($urandom_range(0, 15)), ID_W'($urandom_range(0, 1023)),
                  $urandom(), 1'($urandom_range(0, 1)));
      end else begin
        fill_list(p, $urandom_range(0, 9) != 0);
      end
    end
    item_ch.valid = 1'b0;

    // Drain: every expected result must arrive, then a few more cycles show
    // that nothing extra comes out.
    wait (outstanding == 0);
    repeat (12) @(posedge clk);
    if (fail_count == 0) begin
      $display("[knn_sorted_list_insert_core] OK");
    end else begin
      $display("[knn_sorted_list_insert_core] ERROR");
    end
    $finish;
  end

  // Receiver: cycles through its own modes of always ready, mostly ready,
  // mostly stalled and coin-flip. Once the random traffic is under way it
  // holds off for a long stretch, so the result register fills and the
  // block stops taking items while the sender keeps offering.
  initial begin : receiver
    int mode;
    int span;
    int hold_delay;
    bit hold_done;
    result_ch.ready = 1'b0;
    hold_delay      = 200;
    hold_done       = 1'b0;
    wait (!rst);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(16, 160);
      repeat (span) begin
        @(negedge clk);
        if (random_phase && !hold_done) begin
          if (hold_delay == 0) begin
            result_ch.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clk);
            hold_done = 1'b1;
          end else begin
            hold_delay--;
          end
        end
        case (mode)
          0:       result_ch.ready = 1'b1;
          1:       result_ch.ready = ($urandom_range(0, 3) != 0);
          2:       result_ch.ready = ($urandom_range(0, 4) == 0);
          default: result_ch.ready = 1'($urandom_range(0, 1));
        endcase
      end
    end
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #2_000_000;
    $display("[knn_sorted_list_insert_core] ERROR");
    $finish;
  end

endmodule
